// ===== hdl/scacu_pkg.sv =====
// ----------------------------------------------------------------------------
// Set-associative cache with use-count replacement: shared definitions
// Word types, mode codes, controller commands and size defaults.
// ----------------------------------------------------------------------------
package scacu_pkg;

    localparam int LINE_CNT_DEF   = 64;
    localparam int LINE_BYTES_DEF = 4;

    localparam int WORD_W = 32;
    localparam int USES_W = 16;
    localparam logic [USES_W-1:0] USES_MAX = 16'hFFFF;

    // Configuration register indexes.
    localparam int REG_MODE = 0;

    localparam logic [1:0] MODE_DIRECT   = 2'd0;
    localparam logic [1:0] MODE_TWO_WAY  = 2'd1;
    localparam logic [1:0] MODE_FOUR_WAY = 2'd2;

    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_FILL   = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [WORD_W-1:0] address;
        logic [WORD_W-1:0] write_data;
    } in_word_t;

    typedef struct packed {
        logic              hit;
        logic [WORD_W-1:0] read_data;
        logic [WORD_W-1:0] hit_total;
        logic [WORD_W-1:0] miss_total;
    } out_word_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic read;
        logic eval;
        logic commit;
    } cmd_t;

    function automatic logic [USES_W-1:0] sat_inc(input logic [USES_W-1:0] value);
        logic [USES_W-1:0] result;
        if (value == USES_MAX)
        begin
            result = USES_MAX;
        end
        else
        begin
            result = value + USES_W'(1);
        end
        return result;
    endfunction

endpackage

// ===== hdl/scacu_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module scacu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic                                         re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/scacu_ctrl.sv =====
// ----------------------------------------------------------------------------
// Cache controller
// Sequences capture, row read, way selection and write-back for each word.
// ----------------------------------------------------------------------------
module scacu_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  logic           out_stall,
    output scacu_pkg::cmd_t cmd
);
    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_WRITE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_blocked;

    // A finished result may not overwrite one that is still waiting.
    assign out_blocked = out_valid_reg && out_stall;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_READ:
            begin
                cmd.read   = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                if (!out_blocked)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== hdl/scacu_datapath.sv =====
// ----------------------------------------------------------------------------
// Cache datapath
// Line store in four lane RAMs, valid bits, way selection and totals.
// ----------------------------------------------------------------------------
module scacu_datapath #(
    parameter int LINE_CNT   = scacu_pkg::LINE_CNT_DEF,
    parameter int LINE_BYTES = scacu_pkg::LINE_BYTES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  scacu_pkg::cmd_t      cmd,
    input  logic [1:0]           mode,
    input  scacu_pkg::in_word_t  in_data,
    output scacu_pkg::out_word_t out_data
);
    localparam int WORD_W  = scacu_pkg::WORD_W;
    localparam int USES_W  = scacu_pkg::USES_W;
    localparam int OFF_W   = $clog2(LINE_BYTES + 1) - 1;
    localparam int LINE_W  = $clog2(LINE_CNT);
    localparam int ROWS    = LINE_CNT / 4;
    localparam int ROW_AW  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int BLK_W   = WORD_W - OFF_W;
    localparam int TAG_W   = BLK_W - LINE_W + 2;
    localparam int ENTRY_W = TAG_W + USES_W + WORD_W;
    localparam int SH_W    = $clog2(LINE_W + 1);

    logic                 kind_reg;
    logic [WORD_W-1:0]    addr_reg;
    logic [WORD_W-1:0]    wdata_reg;

    logic                 hit_reg;
    logic [1:0]           lane_reg;
    logic                 wr_reg;
    logic [ENTRY_W-1:0]   entry_reg;
    logic [WORD_W-1:0]    rdata_reg;

    logic [LINE_CNT-1:0]  valid_reg;
    logic [WORD_W-1:0]    hits_reg;
    logic [WORD_W-1:0]    misses_reg;
    scacu_pkg::out_word_t out_reg;

    logic [BLK_W-1:0]     blk;
    logic [ROW_AW-1:0]    row_sel;
    logic [1:0]           base_lane;
    logic [SH_W-1:0]      tag_shift;
    logic [TAG_W-1:0]     tag_now;
    logic                 assoc;

    logic [ENTRY_W-1:0]   rd_entry [4];
    logic [3:0]           lane_we;

    logic                 hit_c;
    logic [1:0]           lane_c;
    logic                 wr_c;
    logic [ENTRY_W-1:0]   entry_c;
    logic [WORD_W-1:0]    rdata_c;

    // Address split under the current mode. The ways of one set always lie
    // in one row of four lines, so a single row read covers the whole set.
    always_comb
    begin
        blk = BLK_W'(addr_reg >> OFF_W);
        case (mode)
            scacu_pkg::MODE_DIRECT:
            begin
                row_sel   = ROW_AW'(blk >> 2);
                base_lane = blk[1:0];
                tag_shift = SH_W'(LINE_W);
                assoc     = 1'b0;
            end
            scacu_pkg::MODE_TWO_WAY:
            begin
                row_sel   = ROW_AW'(blk >> 1);
                base_lane = {blk[0], 1'b0};
                tag_shift = SH_W'(LINE_W - 1);
                assoc     = 1'b1;
            end
            default:
            begin
                row_sel   = ROW_AW'(blk);
                base_lane = 2'b00;
                tag_shift = SH_W'(LINE_W - 2);
                assoc     = 1'b1;
            end
        endcase
        row_sel = row_sel & ROW_AW'(ROWS - 1);
        tag_now = TAG_W'(blk >> tag_shift);
    end

    genvar g;
    generate
        for (g = 0; g < 4; g++)
        begin : g_lane
            scacu_ram #(
                .WIDTH (ENTRY_W),
                .DEPTH (ROWS)
            ) u_ram (
                .clk   (clk),
                .we    (lane_we[g]),
                .waddr (row_sel),
                .wdata (entry_reg),
                .re    (cmd.read),
                .raddr (row_sel),
                .rdata (rd_entry[g])
            );
            assign lane_we[g] = cmd.commit && wr_reg && (lane_reg == 2'(g));
        end
    endgenerate

    // Way selection: first matching way, else the first way with the
    // smallest use count. An invalid line counts as never used.
    always_comb
    begin
        logic [3:0]              in_set;
        logic [3:0]              match;
        logic [USES_W-1:0]       uses_eff [4];
        logic [ROW_AW+1:0]       line_full;
        logic [LINE_W-1:0]       lane_line;
        logic                    lane_valid;
        logic                    have_min;
        logic [USES_W-1:0]       min_uses;
        logic [1:0]              min_lane;
        logic                    found;
        logic [1:0]              match_lane;
        logic [USES_W-1:0]       uses_pick;
        logic [USES_W-1:0]       uses_new;
        logic [TAG_W-1:0]        tag_pick;
        logic [WORD_W-1:0]       word_pick;

        have_min   = 1'b0;
        min_uses   = '0;
        min_lane   = base_lane;
        found      = 1'b0;
        match_lane = 2'b00;
        for (int l = 0; l < 4; l++)
        begin
            case (mode)
                scacu_pkg::MODE_DIRECT:  in_set[l] = (2'(l) == base_lane);
                scacu_pkg::MODE_TWO_WAY: in_set[l] = (l / 2 == int'(base_lane[1]));
                default:                 in_set[l] = 1'b1;
            endcase
            line_full   = {row_sel, 2'(l)};
            lane_line   = line_full[LINE_W-1:0];
            lane_valid  = valid_reg[lane_line];
            uses_eff[l] = lane_valid ? rd_entry[l][WORD_W +: USES_W] : '0;
            match[l]    = in_set[l] && lane_valid &&
                          (rd_entry[l][ENTRY_W-1 -: TAG_W] == tag_now);
            if (match[l] && !found)
            begin
                found      = 1'b1;
                match_lane = 2'(l);
            end
            if (in_set[l] && (!have_min || uses_eff[l] < min_uses))
            begin
                have_min = 1'b1;
                min_uses = uses_eff[l];
                min_lane = 2'(l);
            end
        end

        if (kind_reg == scacu_pkg::KIND_LOOKUP)
        begin
            lane_c = match_lane;
        end
        else if (found)
        begin
            lane_c = match_lane;
        end
        else
        begin
            lane_c = min_lane;
        end

        uses_pick = uses_eff[lane_c];
        tag_pick  = rd_entry[lane_c][ENTRY_W-1 -: TAG_W];
        word_pick = rd_entry[lane_c][WORD_W-1:0];
        uses_new  = assoc ? scacu_pkg::sat_inc(uses_pick) : uses_pick;

        if (kind_reg == scacu_pkg::KIND_LOOKUP)
        begin
            hit_c   = found;
            rdata_c = found ? word_pick : '0;
            wr_c    = found && assoc;
            entry_c = {tag_pick, uses_new, word_pick};
        end
        else
        begin
            hit_c   = 1'b0;
            rdata_c = '0;
            wr_c    = 1'b1;
            entry_c = {tag_now, uses_new, wdata_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg  <= in_data.kind;
            addr_reg  <= in_data.address;
            wdata_reg <= in_data.write_data;
        end
        if (cmd.eval)
        begin
            hit_reg   <= hit_c;
            lane_reg  <= lane_c;
            wr_reg    <= wr_c;
            entry_reg <= entry_c;
            rdata_reg <= rdata_c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            hits_reg   <= '0;
            misses_reg <= '0;
            out_reg    <= '0;
        end
        else if (cmd.commit)
        begin
            logic [ROW_AW+1:0] wline_full;
            logic [WORD_W-1:0] hits_next;
            logic [WORD_W-1:0] misses_next;
            wline_full  = {row_sel, lane_reg};
            hits_next   = hits_reg;
            misses_next = misses_reg;
            if (wr_reg)
            begin
                valid_reg[wline_full[LINE_W-1:0]] <= 1'b1;
            end
            if (kind_reg == scacu_pkg::KIND_LOOKUP)
            begin
                if (hit_reg)
                begin
                    hits_next = hits_reg + WORD_W'(1);
                end
                else
                begin
                    misses_next = misses_reg + WORD_W'(1);
                end
            end
            hits_reg           <= hits_next;
            misses_reg         <= misses_next;
            out_reg.hit        <= hit_reg;
            out_reg.read_data  <= rdata_reg;
            out_reg.hit_total  <= hits_next;
            out_reg.miss_total <= misses_next;
        end
    end

    assign out_data = out_reg;

endmodule

// ===== hdl/set_assoc_cache_use_count_replace_core.sv =====
// ----------------------------------------------------------------------------
// Set-associative cache with use-count replacement
// Word-per-line tag and data store, direct mapped, two-way or four-way.
// ----------------------------------------------------------------------------
//  Channel  Signals                           Word / register
//  in       in_valid, in_stall, in_data       kind, address, write_data
//  out      out_valid, out_stall, out_data    hit, read_data, hit_total, miss_total
//  config   psel, penable, pwrite, paddr,     mode at byte address 0
//           pwdata, prdata, pready
//
// Each word passes through four steps: capture, row read from the lane RAMs, tag
// compare and way choice, then write-back with the result loaded.
// A stalled result holds the write-back step until the output register frees.
// Reset clears the valid bits, totals and mode at once; no clearing pass runs.
// The next word is accepted while a finished result still waits on out.
// ----------------------------------------------------------------------------
module set_assoc_cache_use_count_replace_core #(
    parameter int LINE_CNT   = scacu_pkg::LINE_CNT_DEF,
    parameter int LINE_BYTES = scacu_pkg::LINE_BYTES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  scacu_pkg::in_word_t  in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output scacu_pkg::out_word_t out_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    logic [1:0]      mode_reg;
    logic            mode_sel;
    scacu_pkg::cmd_t cmd;

    assign pready   = 1'b1;
    assign mode_sel = (paddr == 3'(4 * scacu_pkg::REG_MODE));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= scacu_pkg::MODE_DIRECT;
        end
        else if (psel && penable && pwrite && pready && mode_sel)
        begin
            mode_reg <= pwdata[1:0];
        end
    end

    assign prdata = mode_sel ? {30'd0, mode_reg} : 32'd0;

    scacu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    scacu_datapath #(
        .LINE_CNT   (LINE_CNT),
        .LINE_BYTES (LINE_BYTES)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .mode     (mode_reg),
        .in_data  (in_data),
        .out_data (out_data)
    );

endmodule

// ===== dv/cache_lfu_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Cache checker: use-count replacement predictor and result comparison
// Tracks the mode register from the configuration port and keeps its own copy
// of the cache lines. Every accepted lookup or fill word yields a predicted
// result, which is compared field by field with the next accepted result.
// ----------------------------------------------------------------------------
module cache_lfu_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  scacu_pkg::in_word_t  in_data,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  scacu_pkg::out_word_t out_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic                 pready,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output int                   fail_cnt,
    output int                   pend_cnt
);

    localparam int LINES    = scacu_pkg::LINE_CNT_DEF;
    localparam int WORD_W   = scacu_pkg::WORD_W;
    localparam int USES_W   = scacu_pkg::USES_W;
    localparam int OFS_BITS = $clog2(scacu_pkg::LINE_BYTES_DEF);
    // The four-way split leaves the widest tag.
    localparam int TAG_W    = WORD_W - OFS_BITS - $clog2(LINES / 4);

    logic [1:0]           mode_q;
    logic                 line_valid_q [LINES];
    logic [TAG_W-1:0]     line_tag_q   [LINES];
    logic [USES_W-1:0]    line_uses_q  [LINES];
    logic [WORD_W-1:0]    line_word_q  [LINES];
    logic [WORD_W-1:0]    hits_q;
    logic [WORD_W-1:0]    misses_q;
    scacu_pkg::out_word_t replies_due [$];
    scacu_pkg::out_word_t due;
    int                   bad_cnt;

    function automatic scacu_pkg::out_word_t access_cache(input scacu_pkg::in_word_t w);
        int                   ways;
        int                   sets;
        int                   base;
        int                   pick;
        int                   ln;
        logic [WORD_W-1:0]    blk;
        logic [TAG_W-1:0]     tag;
        logic [USES_W-1:0]    least;
        logic                 found;
        scacu_pkg::out_word_t res;
        ways = (mode_q == scacu_pkg::MODE_DIRECT) ? 1 :
               ((mode_q == scacu_pkg::MODE_TWO_WAY) ? 2 : 4);
        sets = LINES / ways;
        blk  = w.address >> OFS_BITS;
        base = int'(blk % WORD_W'(sets)) * ways;
        tag  = TAG_W'(blk / WORD_W'(sets));
        res  = '0;
        if (w.kind == scacu_pkg::KIND_LOOKUP)
        begin
            for (int i = 0; i < ways; i++)
            begin
                ln = base + i;
                if (!res.hit && line_valid_q[ln] && line_tag_q[ln] == tag)
                begin
                    res.hit       = 1'b1;
                    res.read_data = line_word_q[ln];
                    if (ways > 1 && line_uses_q[ln] != scacu_pkg::USES_MAX)
                    begin
                        line_uses_q[ln] = line_uses_q[ln] + 1'b1;
                    end
                end
            end
            if (res.hit)
            begin
                hits_q = hits_q + 1'b1;
            end
            else
            begin
                misses_q = misses_q + 1'b1;
            end
        end
        else
        begin
            pick  = base;
            found = 1'b0;
            if (ways > 1)
            begin
                // A matching way wins outright; otherwise the first way with
                // the strictly smallest count is taken.
                least = line_uses_q[base];
                for (int i = 0; i < ways; i++)
                begin
                    ln = base + i;
                    if (!found)
                    begin
                        if (line_valid_q[ln] && line_tag_q[ln] == tag)
                        begin
                            pick  = ln;
                            found = 1'b1;
                        end
                        else if (line_uses_q[ln] < least)
                        begin
                            pick  = ln;
                            least = line_uses_q[ln];
                        end
                    end
                end
            end
            line_valid_q[pick] = 1'b1;
            line_tag_q[pick]   = tag;
            line_word_q[pick]  = w.write_data;
            if (ways > 1 && line_uses_q[pick] != scacu_pkg::USES_MAX)
            begin
                line_uses_q[pick] = line_uses_q[pick] + 1'b1;
            end
        end
        res.hit_total  = hits_q;
        res.miss_total = misses_q;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_q = scacu_pkg::MODE_DIRECT;
            for (int i = 0; i < LINES; i++)
            begin
                line_valid_q[i] = 1'b0;
                line_tag_q[i]   = '0;
                line_uses_q[i]  = '0;
                line_word_q[i]  = '0;
            end
            hits_q   = '0;
            misses_q = '0;
            replies_due.delete();
            bad_cnt  = 0;
            fail_cnt <= 0;
            pend_cnt <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (replies_due.size() == 0)
                begin
                    bad_cnt++;
                    if (bad_cnt <= 10)
                    begin
                        $display("%0t: result word with none outstanding: hit=%0d data=%h",
                                 $realtime, out_data.hit, out_data.read_data);
                    end
                end
                else
                begin
                    due = replies_due.pop_front();
                    if (out_data.hit !== due.hit || out_data.read_data !== due.read_data ||
                        out_data.hit_total !== due.hit_total ||
                        out_data.miss_total !== due.miss_total)
                    begin
                        bad_cnt++;
                        if (bad_cnt <= 10)
                        begin
                            $display({"%0t: result mismatch: expected ",
                                      "hit=%0d data=%h hits=%0d misses=%0d"},
                                     $realtime, due.hit, due.read_data, due.hit_total,
                                     due.miss_total);
                            $display({"%0t:                  got      ",
                                      "hit=%0d data=%h hits=%0d misses=%0d"},
                                     $realtime, out_data.hit, out_data.read_data,
                                     out_data.hit_total, out_data.miss_total);
                        end
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                replies_due = {replies_due, access_cache(in_data)};
            end
            if (psel && penable && pwrite && pready &&
                paddr == 3'(4 * scacu_pkg::REG_MODE))
            begin
                mode_q = pwdata[1:0];
            end
            fail_cnt <= bad_cnt;
            pend_cnt <= replies_due.size();
        end
    end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the use-count replacement cache core
// Drives lookup and fill words through all modes, including the spare mode
// value, with random idling on both channels. A separate checker predicts
// every result.
// ----------------------------------------------------------------------------
module tb;

    localparam logic [1:0] MODE_SPARE  = 2'd3;
    localparam int         STALL_LIMIT = 1000;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    scacu_pkg::in_word_t  in_data   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    scacu_pkg::out_word_t out_data;
    logic                 psel      = 1'b0;
    logic                 penable   = 1'b0;
    logic                 pwrite    = 1'b0;
    logic [2:0]           paddr     = '0;
    logic [31:0]          pwdata    = '0;
    logic [31:0]          prdata;
    logic                 pready;
    int                   fail_cnt;
    int                   pend_cnt;

    int          idle_cycles;
    int          hold;
    logic [23:0] tag_pool [6];
    logic [1:0]  phase_mode [6] = '{scacu_pkg::MODE_FOUR_WAY, scacu_pkg::MODE_DIRECT,
                                    scacu_pkg::MODE_TWO_WAY, MODE_SPARE,
                                    scacu_pkg::MODE_TWO_WAY, scacu_pkg::MODE_FOUR_WAY};
    logic        op;
    logic [31:0] addr;
    logic [5:0]  set_idx;

    set_assoc_cache_use_count_replace_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    cache_lfu_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .pready    (pready),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .fail_cnt  (fail_cnt),
        .pend_cnt  (pend_cnt)
    );

    always #1 clk = ~clk;

    task automatic send_word(input logic kind_sel, input logic [31:0] byte_addr,
                             input logic [31:0] data);
        int gap;
        gap = $urandom_range(0, 15);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= scacu_pkg::in_word_t'{kind: kind_sel, address: byte_addr,
                                          write_data: data};
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Holds the sender off until every result word has been taken.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pend_cnt != 0) @(posedge clk);
    endtask

    task automatic write_mode(input logic [1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * scacu_pkg::REG_MODE);
        pwdata  <= {30'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // The receiver draws a stall length per word, independent of out_valid.
    initial
    begin
        forever
        begin
            hold = $urandom_range(0, 15);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!(out_valid && !out_stall)) @(posedge clk);
        end
    end

    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        tag_pool[0] = 24'h000000;
        tag_pool[1] = 24'hFFFFFF;
        for (int i = 2; i < 6; i++)
        begin
            tag_pool[i] = 24'($urandom());
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Direct mapped from reset: empty miss, offset bits, a fill that
        // overwrites the indexed line.
        send_word(scacu_pkg::KIND_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        send_word(scacu_pkg::KIND_FILL,   32'h0000_0000, 32'hFFFF_FFFF);
        send_word(scacu_pkg::KIND_LOOKUP, 32'h0000_0003, 32'h0000_0000);
        send_word(scacu_pkg::KIND_FILL,   32'hFFFF_FFFF, 32'h0000_0000);
        send_word(scacu_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(scacu_pkg::KIND_FILL,   32'h0000_0100, 32'hA5A5_A5A5);
        send_word(scacu_pkg::KIND_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        send_word(scacu_pkg::KIND_LOOKUP, 32'h0000_0100, 32'h0000_0000);

        // Two-way: the stored line is read back under the new split, then
        // a fill whose tag already sits in the set reuses that way.
        wait_drained();
        write_mode(scacu_pkg::MODE_TWO_WAY);
        send_word(scacu_pkg::KIND_LOOKUP, 32'h0000_0080, 32'h0000_0000);
        send_word(scacu_pkg::KIND_FILL,   32'h0000_0000, 32'h1111_1111);
        send_word(scacu_pkg::KIND_FILL,   32'h0000_0100, 32'h2222_2222);
        send_word(scacu_pkg::KIND_FILL,   32'h0000_0000, 32'h3333_3333);
        send_word(scacu_pkg::KIND_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        send_word(scacu_pkg::KIND_LOOKUP, 32'h0000_0100, 32'h0000_0000);

        // Four-way: a fifth tag in one set forces a replacement.
        wait_drained();
        write_mode(scacu_pkg::MODE_FOUR_WAY);
        send_word(scacu_pkg::KIND_FILL,   32'h0000_0040, 32'h4444_4444);
        send_word(scacu_pkg::KIND_FILL,   32'h0000_0080, 32'h5555_5555);
        send_word(scacu_pkg::KIND_FILL,   32'h0000_00C0, 32'h6666_6666);
        send_word(scacu_pkg::KIND_FILL,   32'h0000_0140, 32'h7777_7777);
        send_word(scacu_pkg::KIND_LOOKUP, 32'h0000_0040, 32'h0000_0000);
        send_word(scacu_pkg::KIND_LOOKUP, 32'h0000_0140, 32'h0000_0000);

        // The spare mode code behaves as four-way.
        wait_drained();
        write_mode(MODE_SPARE);
        send_word(scacu_pkg::KIND_LOOKUP, 32'h0000_0140, 32'h0000_0000);
        send_word(scacu_pkg::KIND_FILL,   32'h0000_0180, 32'h8888_8888);
        send_word(scacu_pkg::KIND_LOOKUP, 32'h0000_00C0, 32'h0000_0000);

        for (int ph = 0; ph < 6; ph++)
        begin
            wait_drained();
            write_mode(phase_mode[ph]);
            repeat (88)
            begin
                op = ($urandom_range(0, 1) == 0) ? scacu_pkg::KIND_LOOKUP
                                                 : scacu_pkg::KIND_FILL;
                // Mostly a few tags crowded into a few sets, so that hits,
                // tag reuse and evictions all occur.
                set_idx = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                      : 6'($urandom_range(0, 3));
                if ($urandom_range(0, 7) == 0)
                begin
                    addr = $urandom();
                end
                else
                begin
                    addr = {tag_pool[$urandom_range(0, 5)], set_idx,
                            2'($urandom_range(0, 3))};
                end
                send_word(op, addr, $urandom());
            end
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (fail_cnt == 0 && pend_cnt == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== set_assoc_cache_use_count_replace_core.f =====
hdl/scacu_pkg.sv
hdl/scacu_ram.sv
hdl/scacu_ctrl.sv
hdl/scacu_datapath.sv
hdl/set_assoc_cache_use_count_replace_core.sv
dv/cache_lfu_checker.sv
dv/tb.sv
